### hw/rtl/tte_pkg.sv
// Shared types and constants for the transposition table engine.
// Used by every RTL file of the block; no dependencies.
package tte_pkg;

    localparam int unsigned TABLE_ENTRIES_DEFAULT = 1024;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned DIGIT_W    = 8;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0]  GENERATION_RESET = 8'd0;
    localparam logic [14:0] MATE_SCORE_RESET = 15'd32000;
    localparam logic [14:0] MATE_BOUND_RESET = 15'd31000;

    localparam logic ACT_STORE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        TYPE_EMPTY = 2'd0,
        TYPE_EXACT = 2'd1,
        TYPE_LOWER = 2'd2,
        TYPE_UPPER = 2'd3
    } entry_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GENERATION = 2'd0,
        REG_MATE_SCORE = 2'd1,
        REG_MATE_BOUND = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
        logic [1:0]         entry_type;
        logic signed [7:0]  depth;
        logic [15:0]        move_in;
        logic signed [15:0] value_in;
        logic [6:0]         ply_from_root;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } item_word_t;

    typedef struct packed {
        logic               found;
        logic               usable;
        logic signed [15:0] score;
        logic [15:0]        best_move;
        logic               stored;
        logic [COUNT_W-1:0] occupied_count;
    } result_word_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [7:0]  depth;
        logic [15:0]        move;
        logic signed [15:0] value;
        logic [7:0]         age;
    } slot_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic read;
        logic eval;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic index_done;
    } status_t;

endpackage

### hw/rtl/tte_index.sv
// Slot index unit: key modulo the table size.
// Depends on tte_pkg. Power-of-two sizes register the low key bits,
// other sizes reduce one byte of the key per cycle.
module tte_index #(
    parameter int unsigned TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tte_pkg::KEY_W-1:0]        key,
    output logic                             done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] index
);

    localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
    localparam bit          IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

    logic done_reg;
    logic done_next;

    assign done = done_reg;

    generate
        if (IS_POW2) begin : g_pow2
            logic [IDX_W-1:0] index_reg;

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    index_reg <= key[IDX_W-1:0];
                end
            end

            assign done_next = start;
            assign index     = index_reg;
        end else begin : g_iter
            localparam int unsigned RW     = IDX_W + tte_pkg::DIGIT_W;
            localparam int unsigned DIGITS = tte_pkg::KEY_W / tte_pkg::DIGIT_W;
            localparam int unsigned CNT_W  = $clog2(DIGITS);
            localparam logic [RW-1:0]    NV       = RW'(TABLE_ENTRIES);
            localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

            logic [tte_pkg::KEY_W-1:0] shift_reg;
            logic [IDX_W-1:0]          rem_reg;
            logic [IDX_W-1:0]          rem_next;
            logic [CNT_W-1:0]          cnt_reg;
            logic                      busy_reg;
            logic [RW-1:0]             r;

            // fold in the next byte, then trial-subtract N shifted down to N
            always_comb
            begin
                r = {rem_reg, shift_reg[tte_pkg::KEY_W-1 -: tte_pkg::DIGIT_W]};
                for (int j = tte_pkg::DIGIT_W - 1; j >= 0; j--)
                begin
                    if (r >= (NV << j))
                    begin
                        r = r - (NV << j);
                    end
                end
                rem_next = r[IDX_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shift_reg <= key;
                    rem_reg   <= '0;
                end else if (busy_reg)
                begin
                    shift_reg <= shift_reg << tte_pkg::DIGIT_W;
                    rem_reg   <= rem_next;
                end
            end

            assign done_next = busy_reg && (cnt_reg == CNT_LAST);
            assign index     = rem_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end else
        begin
            done_reg <= done_next;
        end
    end

endmodule

### hw/rtl/tte_dp.sv
// Datapath: configuration registers, key and slot memories, store decision,
// score correction and the result register. Depends on tte_pkg, tte_index.
module tte_dp #(
    parameter int unsigned TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tte_pkg::cmd_t                      cmd,
    output tte_pkg::status_t                   status,
    input  tte_pkg::item_word_t                item,
    output tte_pkg::result_word_t              result,
    input  logic                               cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_ENTRIES - 1);

    // storage
    logic [tte_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
    tte_pkg::slot_t            slot_mem [TABLE_ENTRIES];

    logic [7:0]  generation_reg;
    logic [14:0] mate_score_reg;
    logic [14:0] mate_bound_reg;

    logic [IDX_W-1:0]            clear_addr_reg;
    logic [tte_pkg::COUNT_W-1:0] fill_reg;

    tte_pkg::item_word_t       item_reg;
    logic [tte_pkg::KEY_W-1:0] rd_key_reg;
    tte_pkg::slot_t            rd_slot_reg;

    logic               found_reg;
    logic               usable_reg;
    logic               stored_reg;
    logic [15:0]        move_reg;
    logic signed [15:0] value_reg;

    tte_pkg::result_word_t result_reg;

    logic [IDX_W-1:0] idx;

    // evaluation signals
    logic               slot_empty;
    logic               key_hit;
    logic               store_ok;
    logic               fill_inc;
    logic [15:0]        store_move;
    tte_pkg::slot_t     new_slot;
    logic [16:0]        vext;
    logic [16:0]        mag;
    logic               is_mate;
    logic [15:0]        mate_pos;
    logic [15:0]        mate_neg;
    logic signed [15:0] rebased;
    logic               lookup;
    logic signed [15:0] clamped;

    tte_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.capture),
        .key   (item.key),
        .done  (status.index_done),
        .index (idx)
    );

    assign status.clear_last = (clear_addr_reg == LAST_ADDR);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generation_reg <= tte_pkg::GENERATION_RESET;
            mate_score_reg <= tte_pkg::MATE_SCORE_RESET;
            mate_bound_reg <= tte_pkg::MATE_BOUND_RESET;
        end else if (cfg_we)
        begin
            unique case (cfg_index)
                tte_pkg::REG_GENERATION: generation_reg <= cfg_data[7:0];
                tte_pkg::REG_MATE_SCORE: mate_score_reg <= cfg_data;
                tte_pkg::REG_MATE_BOUND: mate_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lookup     = (item_reg.action == tte_pkg::ACT_LOOKUP);
        slot_empty = (rd_slot_reg.kind == tte_pkg::TYPE_EMPTY);
        key_hit    = (rd_key_reg == item_reg.key);

        store_ok = 1'b0;
        if (item_reg.entry_type != tte_pkg::TYPE_EMPTY)
        begin
            store_ok = slot_empty || key_hit
                    || (rd_slot_reg.age != generation_reg)
                    || ($signed(rd_slot_reg.depth) < $signed(item_reg.depth));
        end
        fill_inc = !lookup && (item_reg.entry_type != tte_pkg::TYPE_EMPTY)
                && slot_empty && (fill_reg != tte_pkg::COUNT_MAX);

        // same key with no move: keep the old one
        store_move = item_reg.move_in;
        if (!slot_empty && key_hit && (item_reg.move_in == 16'd0))
        begin
            store_move = rd_slot_reg.move;
        end

        new_slot.kind  = item_reg.entry_type;
        new_slot.depth = item_reg.depth;
        new_slot.move  = store_move;
        new_slot.value = item_reg.value_in;
        new_slot.age   = generation_reg;

        // mate re-basing
        vext     = {rd_slot_reg.value[15], rd_slot_reg.value};
        mag      = vext[16] ? (17'd0 - vext) : vext;
        is_mate  = (mag >= {2'b00, mate_bound_reg});
        mate_pos = {1'b0, mate_score_reg} - {9'd0, item_reg.ply_from_root};
        mate_neg = {9'd0, item_reg.ply_from_root} - {1'b0, mate_score_reg};
        rebased  = rd_slot_reg.value;
        if (is_mate)
        begin
            rebased = (!vext[16] && (vext != 17'd0)) ? $signed(mate_pos) : $signed(mate_neg);
        end
    end

    // bound clamping on the rebased value
    always_comb
    begin
        case (rd_slot_reg.kind)
            tte_pkg::TYPE_LOWER:
                clamped = (value_reg > item_reg.beta) ? value_reg : item_reg.beta;
            tte_pkg::TYPE_UPPER:
                clamped = (value_reg < item_reg.alpha) ? value_reg : item_reg.alpha;
            default:
                clamped = value_reg;
        endcase
    end

    // control-side counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            fill_reg       <= '0;
        end else
        begin
            if (cmd.clear)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (cmd.eval && fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            slot_mem[clear_addr_reg] <= '0;
        end else if (cmd.eval && !lookup && store_ok)
        begin
            slot_mem[idx] <= new_slot;
        end
        if (cmd.read)
        begin
            rd_slot_reg <= slot_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && !lookup && store_ok)
        begin
            key_mem[idx] <= item_reg.key;
        end
        if (cmd.read)
        begin
            rd_key_reg <= key_mem[idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.eval)
        begin
            found_reg  <= lookup && !slot_empty && key_hit;
            usable_reg <= lookup && !slot_empty && key_hit
                       && !($signed(rd_slot_reg.depth) < $signed(item_reg.depth));
            stored_reg <= !lookup && store_ok;
            move_reg   <= (lookup && !slot_empty && key_hit) ? rd_slot_reg.move : 16'd0;
            value_reg  <= rebased;
        end
        if (cmd.finish)
        begin
            result_reg.found          <= found_reg;
            result_reg.usable         <= usable_reg;
            result_reg.score          <= usable_reg ? clamped : 16'sd0;
            result_reg.best_move      <= move_reg;
            result_reg.stored         <= stored_reg;
            result_reg.occupied_count <= fill_reg;
        end
    end

    assign result = result_reg;

endmodule

### hw/rtl/tte_ctrl.sv
// Controller state machine: sequences clear pass, index, read, evaluate
// and result load. Depends on tte_pkg.
module tte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output tte_pkg::cmd_t     cmd,
    input  tte_pkg::status_t  status
);

    tte_pkg::state_t state_reg;
    tte_pkg::state_t state_next;
    logic            result_valid_reg;
    logic            result_valid_next;
    logic            out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tte_pkg::ST_CLEAR:  if (status.clear_last) state_next = tte_pkg::ST_IDLE;
            tte_pkg::ST_IDLE:   if (item_valid) state_next = tte_pkg::ST_HASH;
            tte_pkg::ST_HASH:   if (status.index_done) state_next = tte_pkg::ST_READ;
            tte_pkg::ST_READ:   state_next = tte_pkg::ST_EVAL;
            tte_pkg::ST_EVAL:   state_next = tte_pkg::ST_FINISH;
            tte_pkg::ST_FINISH: if (out_free) state_next = tte_pkg::ST_IDLE;
            default:            state_next = tte_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        item_stall  = 1'b1;
        unique case (state_reg)
            tte_pkg::ST_CLEAR:  cmd.clear = 1'b1;
            tte_pkg::ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            tte_pkg::ST_HASH:   ;
            tte_pkg::ST_READ:   cmd.read = 1'b1;
            tte_pkg::ST_EVAL:   cmd.eval = 1'b1;
            tte_pkg::ST_FINISH: cmd.finish = out_free;
            default:            ;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (cmd.finish)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tte_pkg::ST_CLEAR;
            result_valid_reg <= 1'b0;
        end else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // a result word appears only from a finishing item
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == tte_pkg::ST_FINISH))
        else $error("result word appeared without a finishing item");

    // no item taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tte_pkg::ST_CLEAR) |-> item_stall)
        else $error("item accepted during clearing pass");

    // an accepted item goes straight to indexing
    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == tte_pkg::ST_HASH))
        else $error("accepted item did not enter indexing");

    // the index unit reports only for the item being indexed
    a_index_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        status.index_done |-> (state_reg == tte_pkg::ST_HASH))
        else $error("index done outside indexing state");

    // a finishing item never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !cmd.finish)
        else $error("result word overwritten while stalled");

endmodule

### hw/rtl/transposition_table_engine.sv
// Transposition table engine: direct-mapped table of search results, depth/age replacement.
// An item is indexed (low key bits if TABLE_ENTRIES is a power of two, else byte-wise key
// reduction), read, evaluated and loaded into the result word; the next item is taken only
// after the index unit, the registered memory read, evaluation, result load and the return to
// idle. A result word may wait while the next item runs. Reset: rst_n clears control at once,
// then a pass empties every slot; items are held off, configuration writes taken.
module transposition_table_engine #(
    parameter int unsigned TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            item_valid,
    output logic                            item_stall,
    input  tte_pkg::item_word_t             item,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output tte_pkg::result_word_t           result,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tte_pkg::cmd_t    cmd;
    tte_pkg::status_t status;

    // Configuration writes land directly in the datapath registers; the user must send them
    // only while the engine is idle. The block does not enforce this; it accepts them every cycle.
    assign cfg_ready = 1'b1;

    // Controller: sequences clear pass, key reduction, memory read,
    // store/lookup evaluation and the load of the result word.
    tte_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // Datapath: memories, replacement decision, mate re-basing and
    // window clamping, fill count and the result register.
    tte_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
